FILE: src/fhos_pkg.sv
// shared constants and conversion functions for the outward snap block
package fhos_pkg;

    localparam logic [15:0] HALF_QNAN = 16'h7E00;
    localparam logic [15:0] HALF_INF  = 16'h7C00;
    localparam logic [15:0] HALF_SIGN = 16'h8000;
    localparam logic [12:0] RND_HALF  = 13'h1000;
    localparam logic [7:0]  EXP_ALL1  = 8'hFF;

    // binary32 to binary16, round to nearest even
    function automatic logic [15:0] half_nearest(input logic [31:0] x);
        logic [15:0] sign;
        logic [7:0]  biased;
        logic [23:0] mant;
        logic [8:0]  e;
        logic [4:0]  sh;
        logic [23:0] q;
        logic [23:0] rem;
        logic [23:0] hlf;
        logic [15:0] hb;
        logic [12:0] r13;
        logic [15:0] res;
        sign   = {x[31], 15'd0};
        biased = x[30:23];
        mant   = {1'b1, x[22:0]};
        e      = {1'b0, biased} - 9'd112;
        sh     = 5'd0;
        q      = 24'd0;
        rem    = 24'd0;
        hlf    = 24'd0;
        hb     = 16'd0;
        r13    = x[12:0];
        if (biased == EXP_ALL1)
        begin
            res = sign | ((x[22:0] != 23'd0) ? HALF_QNAN : HALF_INF);
        end
        else if (biased >= 8'd143)
        begin
            res = sign | HALF_INF;
        end
        else if (biased <= 8'd112)
        begin
            if (biased < 8'd102)
            begin
                res = sign;
            end
            else
            begin
                sh  = 5'(8'd126 - biased);
                q   = mant >> sh;
                rem = mant & ((24'd1 << sh) - 24'd1);
                hlf = 24'd1 << (sh - 5'd1);
                if (rem > hlf || (rem == hlf && q[0]))
                begin
                    q = q + 24'd1;
                end
                res = sign | q[15:0];
            end
        end
        else
        begin
            hb = {1'b0, e[4:0], x[22:13]};
            if (r13 > RND_HALF || (r13 == RND_HALF && hb[0]))
            begin
                hb = hb + 16'd1;
            end
            res = hb | sign;
        end
        return res;
    endfunction

    // exact binary16 to binary32
    function automatic logic [31:0] half_to_single(input logic [15:0] h);
        logic [4:0]  e;
        logic [9:0]  m;
        logic [7:0]  ee;
        logic [3:0]  lz;
        logic [31:0] res;
        e  = h[14:10];
        m  = h[9:0];
        lz = 4'd0;
        ee = 8'd0;
        if (e == 5'd0)
        begin
            if (m == 10'd0)
            begin
                res = {h[15], 31'd0};
            end
            else
            begin
                for (int i = 0; i < 10; i++)
                begin
                    if (m[i])
                    begin
                        lz = 4'(9 - i);
                    end
                end
                m   = m << (lz + 4'd1);
                ee  = 8'd112 - {4'd0, lz};
                res = {h[15], ee, m, 13'd0};
            end
        end
        else if (e == 5'h1F)
        begin
            res = {h[15], EXP_ALL1, m, 13'd0};
        end
        else
        begin
            res = {h[15], 8'({3'd0, e} + 8'd112), m, 13'd0};
        end
        return res;
    endfunction

    function automatic logic [15:0] half_key(input logic [15:0] h);
        return h[15] ? ~h : (h | HALF_SIGN);
    endfunction

    function automatic logic [15:0] half_unkey(input logic [15:0] k);
        return k[15] ? {1'b0, k[14:0]} : ~k;
    endfunction

endpackage

FILE: src/float_to_half_outward_snap.sv
// outward snap of a binary32 value onto the binary16 grid, four stage pipeline
//
//  channel | ports                        | handshake
//  --------+------------------------------+------------------------------
//  in      | value_bits, up_dir           | start & !busy
//  out     | half_code, snapped_bits      | done, one cycle, no backpressure
//
// one beat per cycle; busy is tied low
// stage 1 rounds to nearest half, stage 2 decodes it back, stage 3 compares
// and steps, stage 4 decodes the final half
// rst_n clears only the valid bits
module float_to_half_outward_snap
    import fhos_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] value_bits,
    input  logic        up_dir,
    output logic        done,
    output logic [15:0] half_code,
    output logic [31:0] snapped_bits
);

    logic [3:0]  vld_reg;
    logic [31:0] x1_reg, x2_reg, x3_reg;
    logic        up1_reg, up2_reg;
    logic [15:0] h1_reg, h2_reg, h3_reg, h_out_reg;
    logic [31:0] d2_reg, s_out_reg;
    logic        nf3_reg;
    logic [15:0] h3_next;

    assign busy = 1'b0;

    // compare as sign-magnitude ordering, both zeros equal
    function automatic logic order_lt(input logic [31:0] a, input logic [31:0] b);
        logic az, bz;
        az = a[30:0] == 31'd0;
        bz = b[30:0] == 31'd0;
        if (az && bz)
            return 1'b0;
        if (a[31] != b[31] || az || bz)
        begin
            return (az ? 1'b0 : a[31]) && !(bz ? 1'b0 : b[31]) ||
                   (az && !b[31]) == 1'b0 && (bz && a[31]) ||
                   (az && b[31] && 1'b0) || (!a[31] && !az && bz && 1'b0) ||
                   (az && b[31] == 1'b0 && 1'b0) ||
                   (!az && !bz && a[31] && !b[31]) ||
                   (az && !bz && !b[31]);
        end
        return a[31] ? (a[30:0] > b[30:0]) : (a[30:0] < b[30:0]);
    endfunction

    always_comb
    begin
        h3_next = h2_reg;
        if (up2_reg)
        begin
            if (order_lt(d2_reg, x2_reg) && !(h2_reg == HALF_INF))
                h3_next = half_unkey(half_key(h2_reg) + 16'd1);
        end
        else if (order_lt(x2_reg, d2_reg) && !(h2_reg == (HALF_SIGN | HALF_INF)))
        begin
            h3_next = half_unkey(half_key(h2_reg) - 16'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 4'd0;
        end
        else
        begin
            vld_reg <= {vld_reg[2:0], start};
        end
    end

    always_ff @(posedge clk)
    begin
        x1_reg    <= value_bits;
        up1_reg   <= up_dir;
        h1_reg    <= half_nearest(value_bits);
        x2_reg    <= x1_reg;
        up2_reg   <= up1_reg;
        h2_reg    <= h1_reg;
        d2_reg    <= half_to_single(h1_reg);
        x3_reg    <= x2_reg;
        nf3_reg   <= x2_reg[30:23] == EXP_ALL1;
        h3_reg    <= (x2_reg[30:23] == EXP_ALL1) ? h2_reg : h3_next;
        h_out_reg <= h3_reg;
        s_out_reg <= nf3_reg ? x3_reg : half_to_single(h3_reg);
    end

    assign done         = vld_reg[3];
    assign half_code    = h_out_reg;
    assign snapped_bits = s_out_reg;

`ifndef SYNTHESIS
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##4 done) else $error("beat lost");
    a_nodone: assert property (@(posedge clk) disable iff (!rst_n)
        !start |-> ##4 !done) else $error("beat invented");
    a_busy: assert property (@(posedge clk) busy == 1'b0) else $error("busy raised");
`endif

endmodule

FILE: dv/tb_top.sv
// testbench for the binary32 to binary16 outward snap block
module tb_top;
    import fhos_pkg::*;

    class snap_scoreboard;
        logic [15:0] exp_half[$];
        logic [31:0] exp_bits[$];
        int          errors;

        // own predictor of one beat, built from first principles
        static function logic [15:0] round_nearest(logic [31:0] x);
            logic [15:0] s;
            int          ex;
            int          sh;
            logic [23:0] m;
            logic [23:0] q;
            logic [23:0] r;
            logic [23:0] hf;
            logic [15:0] hb;
            s  = x[31] ? 16'h8000 : 16'h0000;
            ex = int'(x[30:23]) - 112;
            m  = {1'b1, x[22:0]};
            if (x[30:23] == 8'hFF)
                return s | ((x[22:0] != 0) ? 16'h7E00 : 16'h7C00);
            if (ex >= 31)
                return s | 16'h7C00;
            if (ex <= 0)
            begin
                if (ex < -10)
                    return s;
                sh = 14 - ex;
                q  = m >> sh;
                r  = m & ((24'd1 << sh) - 1);
                hf = 24'd1 << (sh - 1);
                if (r > hf || (r == hf && q[0]))
                    q = q + 1;
                return s | q[15:0];
            end
            hb = {1'b0, 5'(ex), x[22:13]};
            if (x[12:0] > 13'h1000 || (x[12:0] == 13'h1000 && hb[0]))
                hb = hb + 1;
            return hb | s;
        endfunction

        static function logic [31:0] widen(logic [15:0] h);
            int         ex;
            logic [9:0] m;
            ex = h[14:10];
            m  = h[9:0];
            if (ex == 0)
            begin
                if (m == 0)
                    return {h[15], 31'd0};
                ex = 113;
                while (!m[9])
                begin
                    m  = m << 1;
                    ex = ex - 1;
                end
                m = m << 1;
                ex = ex - 1;
                return {h[15], 8'(ex), m, 13'd0};
            end
            if (ex == 31)
                return {h[15], 8'hFF, m, 13'd0};
            return {h[15], 8'(ex + 112), m, 13'd0};
        endfunction

        static function longint order_of(logic [31:0] x);
            longint mag;
            mag = x[30:0];
            return x[31] ? -mag : mag;
        endfunction

        // ordering key: negative codes reversed below positive ones
        static function logic [15:0] step(logic [15:0] h, bit up);
            logic [15:0] k;
            if (h[14:0] == 15'h7C00 && h[15] == !up)
                return h;
            k = h[15] ? ~h : (h | 16'h8000);
            k = up ? k + 1 : k - 1;
            return k[15] ? {1'b0, k[14:0]} : ~k;
        endfunction

        function void note_input(logic [31:0] x, bit up);
            logic [15:0] h;
            longint      dv;
            longint      xv;
            h = round_nearest(x);
            if (x[30:23] == 8'hFF)
            begin
                exp_half.insert(exp_half.size(), h);
                exp_bits.insert(exp_bits.size(), x);
                return;
            end
            dv = order_of(widen(h));
            xv = order_of(x);
            if (up && dv < xv)
                h = step(h, 1);
            else if (!up && dv > xv)
                h = step(h, 0);
            exp_half.insert(exp_half.size(), h);
            exp_bits.insert(exp_bits.size(), widen(h));
        endfunction

        function void check_result(logic [15:0] h, logic [31:0] b);
            logic [15:0] eh;
            logic [31:0] eb;
            if (exp_half.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected beat half=%h bits=%h", h, b);
                return;
            end
            eh = exp_half.pop_front();
            eb = exp_bits.pop_front();
            if (eh !== h || eb !== b)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp half=%h bits=%h got half=%h bits=%h",
                             eh, eb, h, b);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [31:0] value_bits;
    logic        up_dir;
    logic        done;
    logic [15:0] half_code;
    logic [31:0] snapped_bits;

    snap_scoreboard sb;
    int             idle_cycles;

    float_to_half_outward_snap dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .value_bits(value_bits), .up_dir(up_dir), .done(done),
        .half_code(half_code), .snapped_bits(snapped_bits)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(half_code, snapped_bits);
        if (rst_n && ((start && !busy) || done))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 2000)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // drive one beat and hold it until accepted, with an optional random gap first
    task automatic send_beat(logic [31:0] x, bit up, bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 6) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        value_bits <= x;
        up_dir     <= up;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_input(x, up);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.exp_half.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [31:0] random_value();
        logic [31:0] x;
        int          kind;
        x    = $urandom;
        kind = $urandom_range(0, 9);
        // bias exponents toward the half range and its edges, and low bits toward the rounding tie
        if (kind < 5)
            x[30:23] = 8'($urandom_range(98, 145));
        else if (kind == 5)
            x[12:0] = $urandom_range(0, 1) ? 13'h1000 : 13'h0FFF;
        else if (kind == 6)
            x[30:23] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return x;
    endfunction

    logic [31:0] directed[$];

    initial
    begin
        sb          = new();
        idle_cycles = 0;
        rst_n       = 1'b0;
        start       = 1'b0;
        value_bits  = 32'd0;
        up_dir      = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                     32'h7FC0_0001, 32'hFFA0_0000, 32'h4780_0000, 32'hC780_0000,
                     32'h477F_E000, 32'h477F_F000, 32'h3380_0000, 32'hB300_0001,
                     32'h0000_0001, 32'h3F80_1000, 32'h3F80_3000, 32'hFFFF_FFFF};
        foreach (directed[i])
        begin
            send_beat(directed[i], 1'b0, 1'b0);
            send_beat(directed[i], 1'b1, 1'b0);
        end
        drain();

        for (int n = 0; n < 1300; n++)
        begin
            send_beat(random_value(), $urandom_range(0, 1), $urandom_range(0, 3) != 0);
            if (n == 600)
                drain();
        end
        drain();
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.exp_half.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
